FILE: rtl/core/gkt_pkg.sv
// ----------------------------------------------------------------------------
// gkt_pkg
// Types and codes shared by the keyed table install block and its checker.
// ----------------------------------------------------------------------------
package gkt_pkg;

	localparam int unsigned KeyW = 64;
	localparam int unsigned ValW = 64;

	typedef enum logic [1:0] {
		ST_SUCCESS   = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_NO_RES    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_UPDATED = 2'd1,
		ACT_REMOVED = 2'd2,
		ACT_ADDED   = 2'd3
	} action_t;

	typedef struct packed {
		logic [KeyW-1:0] key_high;
		logic [KeyW-1:0] key_low;
		logic [ValW-1:0] value;
	} entry_t;

endpackage

FILE: rtl/core/guid_keyed_table_install.sv
// ----------------------------------------------------------------------------
// guid_keyed_table_install
// Packed key/value table: update, remove with compaction, or append.
// ----------------------------------------------------------------------------
//  channel   | handshake           | beat
//  ----------+---------------------+-----------------------------------------
//  request   | start & !busy       | key_high, key_low, key_valid, entry_value
//  result    | done (one cycle)    | status, action_taken, slot_index,
//            |                     | entry_count
//
//  Search reads one slot at a time through the entry memory's single read
//  port and one shared 128-bit key comparator, passing S_RD and S_CMP per
//  entry. A removal then moves each later entry down via S_SH_RD and S_SH_WR.
//  busy stays high from the accepted beat until done; results are never held.
//  Reset clears state, done and entry count; slots at or above it go unread.
// ----------------------------------------------------------------------------
module guid_keyed_table_install #(
	parameter int unsigned MAX_TABLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	input  logic        key_valid,
	input  logic [63:0] entry_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [1:0]  action_taken,
	output logic [3:0]  slot_index,
	output logic [4:0]  entry_count
);

	localparam int unsigned IW  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
	localparam int unsigned CW  = $clog2(MAX_TABLES + 1);
	localparam int unsigned CW1 = CW + 1;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHK   = 6'b000010,
		S_RD    = 6'b000100,
		S_CMP   = 6'b001000,
		S_SH_RD = 6'b010000,
		S_SH_WR = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [63:0]       key_high_q, key_low_q, val_q;
	logic              kv_q;
	logic [CW-1:0]     ptr_q, ptr_d;
	logic [CW-1:0]     count_q, count_d;
	logic [IW-1:0]     slot_q, slot_d;

	logic              done_q;
	gkt_pkg::status_t  status_q;
	gkt_pkg::action_t  action_q;
	logic [IW-1:0]     slot_out_q;
	logic [CW-1:0]     count_out_q;

	logic              fin;
	gkt_pkg::status_t  fin_status;
	gkt_pkg::action_t  fin_action;
	logic [IW-1:0]     fin_slot;

	logic              we;
	logic [IW-1:0]     waddr, raddr;
	gkt_pkg::entry_t   wdata, rdata;
	logic              hit;
	logic [CW1-1:0]    ptr_p1, ptr_p2, cnt_w;
	logic              val_zero;

	gkt_store #(
		.DEPTH (MAX_TABLES),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign hit      = (rdata.key_high == key_high_q) && (rdata.key_low == key_low_q);
	assign ptr_p1   = CW1'(ptr_q) + CW1'(1);
	assign ptr_p2   = CW1'(ptr_q) + CW1'(2);
	assign cnt_w    = CW1'(count_q);
	assign val_zero = (val_q == 64'd0);

	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		count_d    = count_q;
		slot_d     = slot_q;
		fin        = 1'b0;
		fin_status = gkt_pkg::ST_SUCCESS;
		fin_action = gkt_pkg::ACT_NONE;
		fin_slot   = '0;
		we         = 1'b0;
		waddr      = ptr_q[IW-1:0];
		wdata      = '{key_high: key_high_q, key_low: key_low_q, value: val_q};
		raddr      = ptr_q[IW-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				ptr_d = '0;
				if (!kv_q) begin
					fin        = 1'b1;
					fin_status = gkt_pkg::ST_INVALID;
				end else if (count_q != '0) begin
					state_d = S_RD;
				end else if (val_zero) begin
					fin        = 1'b1;
					fin_status = gkt_pkg::ST_NOT_FOUND;
				end else begin
					we         = 1'b1;
					waddr      = count_q[IW-1:0];
					count_d    = count_q + CW'(1);
					fin        = 1'b1;
					fin_action = gkt_pkg::ACT_ADDED;
					fin_slot   = count_q[IW-1:0];
				end
			end
			S_RD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (hit) begin
					slot_d = ptr_q[IW-1:0];
					if (!val_zero) begin
						we         = 1'b1;
						fin        = 1'b1;
						fin_action = gkt_pkg::ACT_UPDATED;
						fin_slot   = ptr_q[IW-1:0];
					end else if (ptr_p1 < cnt_w) begin
						state_d = S_SH_RD;
					end else begin
						count_d    = count_q - CW'(1);
						fin        = 1'b1;
						fin_action = gkt_pkg::ACT_REMOVED;
						fin_slot   = ptr_q[IW-1:0];
					end
				end else if (ptr_p1 < cnt_w) begin
					ptr_d   = ptr_p1[CW-1:0];
					state_d = S_RD;
				end else if (val_zero) begin
					fin        = 1'b1;
					fin_status = gkt_pkg::ST_NOT_FOUND;
				end else if (cnt_w >= CW1'(MAX_TABLES)) begin
					fin        = 1'b1;
					fin_status = gkt_pkg::ST_NO_RES;
				end else begin
					we         = 1'b1;
					waddr      = count_q[IW-1:0];
					count_d    = count_q + CW'(1);
					fin        = 1'b1;
					fin_action = gkt_pkg::ACT_ADDED;
					fin_slot   = count_q[IW-1:0];
				end
			end
			S_SH_RD: begin
				raddr   = ptr_p1[IW-1:0];
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				we    = 1'b1;
				wdata = rdata;
				if (ptr_p2 < cnt_w) begin
					ptr_d   = ptr_p1[CW-1:0];
					state_d = S_SH_RD;
				end else begin
					count_d    = count_q - CW'(1);
					fin        = 1'b1;
					fin_action = gkt_pkg::ACT_REMOVED;
					fin_slot   = slot_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		slot_q <= slot_d;
		if (state_q == S_IDLE && start) begin
			key_high_q <= key_high;
			key_low_q  <= key_low;
			kv_q       <= key_valid;
			val_q      <= entry_value;
		end
		if (fin) begin
			status_q    <= fin_status;
			action_q    <= fin_action;
			slot_out_q  <= fin_slot;
			count_out_q <= count_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign action_taken = action_q;
	assign slot_index   = 4'(slot_out_q);
	assign entry_count  = 5'(count_out_q);

endmodule

FILE: rtl/core/gkt_store.sv
// ----------------------------------------------------------------------------
// gkt_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gkt_store #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  gkt_pkg::entry_t      wdata,
	input  logic [AW-1:0]        raddr,
	output gkt_pkg::entry_t      rdata
);

	gkt_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/gkt_checker.sv
// ----------------------------------------------------------------------------
// gkt_checker
// Port-level checks for the keyed table install block, bound to the top level.
// ----------------------------------------------------------------------------
module gkt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [1:0] action_taken,
	input logic [3:0] slot_index
);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in consecutive cycles");

	a_action_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && action_taken != gkt_pkg::ACT_NONE |-> status == gkt_pkg::ST_SUCCESS)
		else $error("action taken on failing status");

	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != gkt_pkg::ST_SUCCESS |-> slot_index == 4'd0
			&& action_taken == gkt_pkg::ACT_NONE)
		else $error("failing status with slot or action");

endmodule

bind guid_keyed_table_install gkt_checker u_gkt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.action_taken (action_taken),
	.slot_index   (slot_index)
);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed table install block. A shadow table in
// the bench predicts status, action, slot and entry count for each request;
// the results are matched in order. Directed beats cover invalid keys,
// extreme keys, filling to overflow and removals with compaction, and a long
// random stretch then alternates between phases that fill and phases that
// drain the table.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TableDepth    = 16;
	localparam int WatchdogLimit = 2000;
	localparam int TailCycles    = 100;
	localparam int RandomPhases  = 10;
	localparam int PhaseBeats    = 100;
	localparam int PoolSize      = 32;

	typedef struct packed {
		gkt_pkg::status_t status;
		gkt_pkg::action_t action;
		logic [3:0]       slot;
		logic [4:0]       count;
	} install_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] key_high = '0;
	logic [63:0] key_low = '0;
	logic        key_valid = 1'b0;
	logic [63:0] entry_value = '0;
	logic        done;
	logic [1:0]  status;
	logic [1:0]  action_taken;
	logic [3:0]  slot_index;
	logic [4:0]  entry_count;

	logic [63:0] shadow_key_high[TableDepth];
	logic [63:0] shadow_key_low[TableDepth];
	logic [63:0] shadow_value[TableDepth];
	int          shadow_count = 0;

	install_result_t expected_q[$];
	int              fail_count = 0;
	int              gap_pct = 0;
	int              idle_cycles = 0;
	logic [127:0]    key_pool[PoolSize];

	guid_keyed_table_install #(
		.MAX_TABLES(TableDepth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.key_high(key_high),
		.key_low(key_low),
		.key_valid(key_valid),
		.entry_value(entry_value),
		.done(done),
		.status(status),
		.action_taken(action_taken),
		.slot_index(slot_index),
		.entry_count(entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Applies one request to the shadow table and returns what the block must report.
	function automatic install_result_t predict_install(input logic [63:0] kh,
			input logic [63:0] kl, input logic kv, input logic [63:0] v);
		install_result_t r;
		int n;
		int hit;
		n = shadow_count;
		hit = -1;
		r.status = gkt_pkg::ST_SUCCESS;
		r.action = gkt_pkg::ACT_NONE;
		r.slot = '0;
		if (!kv) begin
			r.status = gkt_pkg::ST_INVALID;
		end else begin
			for (int k = n - 1; k >= 0; k--) begin
				if (shadow_key_high[k] == kh && shadow_key_low[k] == kl)
					hit = k;
			end
			if (hit >= 0 && v != '0) begin
				shadow_value[hit] = v;
				r.action = gkt_pkg::ACT_UPDATED;
				r.slot = 4'(hit);
			end else if (hit >= 0) begin
				for (int j = hit; j + 1 < n; j++) begin
					shadow_key_high[j] = shadow_key_high[j + 1];
					shadow_key_low[j] = shadow_key_low[j + 1];
					shadow_value[j] = shadow_value[j + 1];
				end
				shadow_key_high[n - 1] = '0;
				shadow_key_low[n - 1] = '0;
				shadow_value[n - 1] = '0;
				shadow_count = n - 1;
				r.action = gkt_pkg::ACT_REMOVED;
				r.slot = 4'(hit);
			end else if (v == '0) begin
				r.status = gkt_pkg::ST_NOT_FOUND;
			end else if (n >= TableDepth) begin
				r.status = gkt_pkg::ST_NO_RES;
			end else begin
				shadow_key_high[n] = kh;
				shadow_key_low[n] = kl;
				shadow_value[n] = v;
				shadow_count = n + 1;
				r.action = gkt_pkg::ACT_ADDED;
				r.slot = 4'(n);
			end
		end
		r.count = 5'(shadow_count);
		return r;
	endfunction

	// Returns at the accepting edge with start high, or after a random gap with start low.
	task automatic send_beat(input logic [63:0] kh, input logic [63:0] kl,
			input logic kv, input logic [63:0] v);
		int gap;
		start <= 1'b1;
		key_high <= kh;
		key_low <= kl;
		key_valid <= kv;
		entry_value <= v;
		do @(posedge clk); while (busy);
		expected_q.push_back(predict_install(kh, kl, kv, v));
		gap = ($urandom_range(99) < gap_pct) ? $urandom_range(6, 1) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_absent_key();
		send_beat(rand64(), rand64(), 1'b0, rand64());
		send_beat('1, '1, 1'b0, '0);
	endtask

	task automatic test_extreme_keys();
		send_beat('1, '1, 1'b1, '1);
		send_beat('0, '0, 1'b1, 64'd1);
		send_beat('1, '1, 1'b1, 64'h8000_0000_0000_0000);
		send_beat('1, '0, 1'b1, '0);
	endtask

	task automatic test_fill_overflow();
		while (shadow_count < TableDepth)
			send_beat(rand64(), rand64(), 1'b1, rand64() | 64'd1);
		send_beat(rand64(), rand64(), 1'b1, rand64() | 64'd1);
		send_beat(shadow_key_high[TableDepth - 1], shadow_key_low[TableDepth - 1], 1'b1,
			rand64() | 64'd1);
	endtask

	task automatic test_remove_shift();
		send_beat(shadow_key_high[0], shadow_key_low[0], 1'b1, '0);
		send_beat(shadow_key_high[shadow_count - 1], shadow_key_low[shadow_count - 1], 1'b1, '0);
		send_beat(shadow_key_high[6], shadow_key_low[6], 1'b1, '0);
		send_beat('0, '0, 1'b1, '0);
	endtask

	// Even phases lean toward filling, odd phases toward draining.
	task automatic test_random_traffic();
		logic [127:0] key;
		logic [63:0]  v;
		logic         kv;
		int           zero_pct;
		int           pick;
		for (int i = 0; i < PoolSize; i++)
			key_pool[i] = {rand64(), rand64()};
		key_pool[0] = '1;
		key_pool[1] = '0;
		key_pool[2] = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
		key_pool[3] = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
		for (int phase = 0; phase < RandomPhases; phase++) begin
			zero_pct = (phase % 2 == 0) ? 8 : 45;
			case ($urandom_range(2))
				0: gap_pct = 0;
				1: gap_pct = 25;
				default: gap_pct = 60;
			endcase
			if (phase >= RandomPhases - 2)
				gap_pct = 0;
			for (int b = 0; b < PhaseBeats; b++) begin
				pick = $urandom_range(99);
				if (pick < 50 && shadow_count > 0) begin
					pick = $urandom_range(shadow_count - 1);
					key = {shadow_key_high[pick], shadow_key_low[pick]};
				end else if (pick < 80) begin
					key = key_pool[$urandom_range(PoolSize - 1)];
				end else if (pick < 92) begin
					key = {rand64(), rand64()};
					key_pool[$urandom_range(PoolSize - 1, 4)] = key;
				end else begin
					key = key_pool[$urandom_range(PoolSize - 1)];
					if (shadow_count > 0) begin
						pick = $urandom_range(shadow_count - 1);
						key = {shadow_key_high[pick], shadow_key_low[pick]};
					end
					key = key ^ (128'd1 << $urandom_range(127));
				end
				kv = ($urandom_range(99) < 4) ? 1'b0 : 1'b1;
				pick = $urandom_range(99);
				if (pick < zero_pct)
					v = '0;
				else if (pick > 96)
					v = '1;
				else
					v = rand64();
				send_beat(key[127:64], key[63:0], kv, v);
			end
		end
	endtask

	always @(posedge clk) begin
		install_result_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: status=%0d action=%0d slot=%0d count=%0d",
						status, action_taken, slot_index, entry_count);
			end else begin
				want = expected_q.pop_front();
				if (status !== want.status || action_taken !== want.action ||
						slot_index !== want.slot || entry_count !== want.count) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"result mismatch: expected status=%0d action=%0d slot=%0d ",
							"count=%0d, got status=%0d action=%0d slot=%0d count=%0d"},
							want.status, want.action, want.slot, want.count,
							status, action_taken, slot_index, entry_count);
				end
			end
		end
	end

	// Watchdog: cycles with neither a request beat nor a result.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < TableDepth; i++) begin
			shadow_key_high[i] = '0;
			shadow_key_low[i] = '0;
			shadow_value[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 30;
		test_absent_key();
		test_extreme_keys();
		test_fill_overflow();
		test_remove_shift();
		test_random_traffic();
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
